FILE: sv/entity_health_fault_latch_table_top_defines.svh
// Assertion macros used by the entity health table top level.
// Depends on nothing; bodies expand to nothing when SYNTHESIS is defined.
`ifndef ENTITY_HEALTH_FAULT_LATCH_TABLE_TOP_DEFINES_SVH
`define ENTITY_HEALTH_FAULT_LATCH_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante
`define EHFL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Check that cons holds in the cycle after ante
`define EHFL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error(msg);
`else
`define EHFL_ASSERT_IMP(lbl, ante, cons, msg)
`define EHFL_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: sv/ehfl_pkg.sv
// Types and constants of the entity health and fault latch table.
// Used by ehfl_table and entity_health_fault_latch_table_top; no dependencies.
package ehfl_pkg;

  typedef enum logic [2:0] {
    OP_HEARTBEAT = 3'd0,
    OP_SET       = 3'd1,
    OP_RESET     = 3'd2,
    OP_LATCH     = 3'd3,
    OP_CLEAR     = 3'd4,
    OP_QUERY     = 3'd5,
    OP_STALE     = 3'd6,
    OP_SNAPSHOT  = 3'd7
  } func_e;

  localparam logic [2:0] HEALTH_OK     = 3'd0;
  localparam logic [2:0] HEALTH_FAILED = 3'd2;
  localparam logic [7:0] NO_REASON     = 8'hFF;

  // One table entry
  typedef struct packed {
    logic [2:0]  health;
    logic [15:0] err_code;
    logic [31:0] heartbeat;
    logic        latched;
    logic [7:0]  reason;
  } entry_t;

endpackage

FILE: sv/ehfl_table.sv
// Entry store: synchronous single-port-read, single-port-write memory with
// per-entry valid bits so unwritten entries read as zero. Uses ehfl_pkg.
module ehfl_table #(
  parameter int Depth = 32,
  parameter int Aw    = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [Aw-1:0]   rd_addr_i,
  output ehfl_pkg::entry_t rd_data_o,
  input  logic            wr_en_i,
  input  logic [Aw-1:0]   wr_addr_i,
  input  ehfl_pkg::entry_t wr_data_i
);

  ehfl_pkg::entry_t mem [Depth];
  logic [Depth-1:0] vld_q;
  ehfl_pkg::entry_t rd_q;
  logic             rd_vld_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // mark entries written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // unwritten entries read as zero
  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

FILE: sv/entity_health_fault_latch_table_top.sv
// Entity health and fault latch table, top level. Uses ehfl_pkg and ehfl_table.
// Result strobe valid_o is registered: accept sets s1_vld_q, which sets out_vld_q.
// busy covers the read-modify-write cycle, so no new item is taken until the last
// is written back; the receiver cannot stall, so no result is lost.
// Reset (async, active low) clears control state, entity_limit and all entry
// valid bits at once; entries read as zero until written. No clearing pass.
`include "entity_health_fault_latch_table_top_defines.svh"
module entity_health_fault_latch_table_top #(
  parameter int ENTITY_COUNT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func_i,
  input  logic [7:0]  entity_id_i,
  input  logic [7:0]  reason_i,
  input  logic [2:0]  health_value_i,
  input  logic [15:0] error_code_in_i,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] max_age_i,
  output logic        valid_o,
  output logic        id_valid_o,
  output logic        flag_out_o,
  output logic [7:0]  prev_reason_o,
  output logic [2:0]  health_out_o,
  output logic [15:0] error_code_out_o,
  output logic [31:0] heartbeat_time_o
);

  localparam int         Aw     = (ENTITY_COUNT > 1) ? $clog2(ENTITY_COUNT) : 1;
  localparam logic [7:0] CountB = 8'(ENTITY_COUNT);

  // configuration
  logic [7:0] limit_q;
  logic [7:0] eff_limit;
  logic       accept;
  logic       id_ok;
  logic [Aw-1:0] rd_addr;

  // work stage
  logic              s1_vld_q;
  ehfl_pkg::func_e   func_q;
  logic [7:0]        reason_q;
  logic [2:0]        hval_q;
  logic [15:0]       ecode_q;
  logic [31:0]       now_q;
  logic [31:0]       max_age_q;
  logic              idv_q;
  logic [Aw-1:0]     addr_q;

  // modify logic
  ehfl_pkg::entry_t  ent;
  ehfl_pkg::entry_t  ent_d;
  logic              wr_en;
  logic              same;
  logic [31:0]       age;
  logic              flag_d;
  logic [7:0]        prev_d;
  logic [2:0]        h_d;
  logic [15:0]       e_d;
  logic [31:0]       t_d;

  // result registers
  logic              out_vld_q;
  logic              idv_out_q;
  logic              flag_q;
  logic [7:0]        prev_q;
  logic [2:0]        h_q;
  logic [15:0]       e_q;
  logic [31:0]       t_q;

  // limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // cap the limit at the table size and check the id
  assign eff_limit = (limit_q > CountB) ? CountB : limit_q;
  assign id_ok     = entity_id_i < eff_limit;
  assign rd_addr   = id_ok ? entity_id_i[Aw-1:0] : '0;
  assign accept    = start && !busy;
  assign busy      = s1_vld_q;

  // work stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  // capture the item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q    <= ehfl_pkg::func_e'(func_i);
      reason_q  <= reason_i;
      hval_q    <= health_value_i;
      ecode_q   <= error_code_in_i;
      now_q     <= now_ms_i;
      max_age_q <= max_age_i;
      idv_q     <= id_ok;
      addr_q    <= rd_addr;
    end
  end

  ehfl_table #(
    .Depth (ENTITY_COUNT),
    .Aw    (Aw)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (ent),
    .wr_en_i   (wr_en),
    .wr_addr_i (addr_q),
    .wr_data_i (ent_d)
  );

  // modify the entry and form the result
  assign same = ent.latched && (ent.reason == reason_q);
  assign age  = now_q - ent.heartbeat;

  always_comb begin
    ent_d  = ent;
    flag_d = 1'b0;
    prev_d = '0;
    h_d    = '0;
    e_d    = '0;
    t_d    = '0;
    wr_en  = s1_vld_q && idv_q;
    if (!idv_q) begin
      if (func_q == ehfl_pkg::OP_CLEAR) begin
        prev_d = ehfl_pkg::NO_REASON;
      end
    end else begin
      unique case (func_q)
        ehfl_pkg::OP_HEARTBEAT: begin
          ent_d.heartbeat = now_q;
          if (ent.health != ehfl_pkg::HEALTH_FAILED) begin
            ent_d.health = ehfl_pkg::HEALTH_OK;
          end
        end
        ehfl_pkg::OP_SET: begin
          ent_d.health   = hval_q;
          ent_d.err_code = ecode_q;
        end
        ehfl_pkg::OP_RESET: begin
          ent_d.health    = ehfl_pkg::HEALTH_OK;
          ent_d.err_code  = '0;
          ent_d.heartbeat = now_q;
        end
        ehfl_pkg::OP_LATCH: begin
          if (same) begin
            flag_d = 1'b1;
          end else begin
            ent_d.latched = 1'b1;
            ent_d.reason  = reason_q;
          end
        end
        ehfl_pkg::OP_CLEAR: begin
          prev_d        = ent.latched ? ent.reason : ehfl_pkg::NO_REASON;
          ent_d.latched = 1'b0;
          ent_d.reason  = '0;
        end
        ehfl_pkg::OP_QUERY: begin
          flag_d = same;
        end
        ehfl_pkg::OP_STALE: begin
          flag_d = (ent.health != ehfl_pkg::HEALTH_FAILED) && (age > max_age_q);
        end
        ehfl_pkg::OP_SNAPSHOT: begin
          h_d = ent.health;
          e_d = ent.err_code;
          t_d = ent.heartbeat;
        end
        default: begin
          ent_d = ent;
        end
      endcase
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= s1_vld_q;
    end
  end

  // hold the result fields
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      idv_out_q <= idv_q;
      flag_q    <= flag_d;
      prev_q    <= prev_d;
      h_q       <= h_d;
      e_q       <= e_d;
      t_q       <= t_d;
    end
  end

  assign valid_o          = out_vld_q;
  assign id_valid_o       = idv_out_q;
  assign flag_out_o       = flag_q;
  assign prev_reason_o    = prev_q;
  assign health_out_o     = h_q;
  assign error_code_out_o = e_q;
  assign heartbeat_time_o = t_q;

  // every accepted item gives a result strobe on valid_o
  `EHFL_ASSERT_NXT(a_item_result, accept, ##1 valid_o, "accepted item gave no result")
  // the read-modify-write cycle blocks new items
  `EHFL_ASSERT_NXT(a_busy_after_accept, accept, busy, "busy not raised after accept")
  // no table read while a write-back is pending
  `EHFL_ASSERT_IMP(a_no_rw_overlap, wr_en, !accept, "read overlaps write-back")
  // a rejected id yields an empty snapshot and no flag
  `EHFL_ASSERT_IMP(a_reject_clean, valid_o && !id_valid_o,
                   !flag_out_o && heartbeat_time_o == 32'd0 && error_code_out_o == 16'd0,
                   "rejected id produced data")

endmodule
